@@ hw/rtl/dea_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, field widths and codes for the disk extent allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package dea_pkg;

    localparam int LEN_W           = 20;
    localparam int KIND_W          = 3;
    localparam int FID_W           = 16;
    localparam int STAT_W          = 2;
    localparam int MAX_EXTENTS_DEF = 32;
    localparam int ID_BITS_DEF     = 16;
    localparam int MAX_RESULTS     = 32;
    localparam int RES_W           = $clog2(MAX_RESULTS + 1);
    localparam logic [LEN_W-1:0] DISK_BLOCKS_RESET = 20'd1024;

    localparam logic [KIND_W-1:0] KIND_FORMAT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHOW    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COMPACT = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DISK_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FID_W-1:0]  file_id;
        logic [LEN_W-1:0]  file_size;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  position;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic squeeze;
        logic phase;
    } cell_ctl_t;

endpackage

@@ hw/rtl/disk_extent_allocator.sv @@
`timescale 1ns / 1ps
// Disk extent allocator top level. One transaction is worked at a time: format, delete
// and show each make one pass over the cell chain, a show pass also waiting on output
// stalls; a write of nonzero size scans once and, unless refused, makes a second pass;
// compact gathers, squeezes, merges and squeezes again; unknown kinds make no pass.
// Reset (rst_n, asynchronous, active low) empties the table and sets disk_blocks to 1024.
// Depends on dea_pkg, dea_cell and dea_seq.
module disk_extent_allocator #(
    parameter int MAX_EXTENTS = dea_pkg::MAX_EXTENTS_DEF,
    parameter int ID_BITS     = dea_pkg::ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  dea_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output dea_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dea_pkg::LEN_W-1:0] cfg_data
);

    localparam int ENTRY_W = 2 + ID_BITS + dea_pkg::LEN_W;

    // The extent table lives in a chain of cells. A shift moves every entry one
    // place toward the head; the sequencer reads the head and feeds the tail, so a
    // pass of N shifts visits every entry and leaves the table in its own order.
    // A squeeze step lets live entries close the holes left by dropped or merged
    // entries; N such steps pack the table at the head again.
    logic [ENTRY_W-1:0] cell_q [MAX_EXTENTS];
    logic [ENTRY_W-1:0] push;
    dea_pkg::cell_ctl_t cell_ctl;

    // The head cell has no left neighbor. It sees a live entry there, so it never
    // gives its own entry away during a squeeze step.
    logic [ENTRY_W-1:0] head_anchor;
    assign head_anchor = {1'b1, {(ENTRY_W - 1){1'b0}}};

    genvar i;
    generate
        for (i = 0; i < MAX_EXTENTS; i++)
        begin : g_cell
            logic [ENTRY_W-1:0] left_in;
            logic [ENTRY_W-1:0] right_in;
            if (i == 0)
            begin : g_head
                assign left_in = head_anchor;
            end
            else
            begin : g_body
                assign left_in = cell_q[i-1];
            end
            if (i == MAX_EXTENTS - 1)
            begin : g_tail
                assign right_in = push;
            end
            else
            begin : g_inner
                assign right_in = cell_q[i+1];
            end
            dea_cell #(
                .ID_BITS (ID_BITS),
                .ENTRY_W (ENTRY_W)
            ) u_cell (
                .clk      (clk),
                .ctl      (cell_ctl),
                .is_odd   (1'(i % 2)),
                .left_in  (left_in),
                .right_in (right_in),
                .q        (cell_q[i])
            );
        end
    endgenerate

    // The sequencer holds the entry count, the volume size register and the
    // output register. It takes a new transaction while a result still waits.
    dea_seq #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .ID_BITS     (ID_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head      (cell_q[0]),
        .push      (push),
        .cell_ctl  (cell_ctl)
    );

endmodule

@@ hw/rtl/dea_cell.sv @@
`timescale 1ns / 1ps
// One cell of the extent chain: holds a single extent entry.
// Depends on dea_pkg for the cell control struct and the length width.
module dea_cell #(
    parameter int ID_BITS = dea_pkg::ID_BITS_DEF,
    parameter int ENTRY_W = 2 + ID_BITS + dea_pkg::LEN_W
) (
    input  logic                    clk,
    input  dea_pkg::cell_ctl_t      ctl,
    input  logic                    is_odd,
    input  logic [ENTRY_W-1:0]      left_in,
    input  logic [ENTRY_W-1:0]      right_in,
    output logic [ENTRY_W-1:0]      q
);

    typedef struct packed {
        logic                      live;
        logic                      free;
        logic [ID_BITS-1:0]        owner;
        logic [dea_pkg::LEN_W-1:0] len;
    } entry_t;

    entry_t q_reg;
    entry_t q_next;
    entry_t lft;
    entry_t rgt;
    logic   left_role;

    assign lft       = left_in;
    assign rgt       = right_in;
    assign left_role = (is_odd == ctl.phase);
    assign q         = q_reg;

    // A squeeze step swaps a hole with a live entry on its right, so live
    // entries drift toward the head while keeping their order.
    always_comb
    begin
        q_next = q_reg;
        if (ctl.shift)
        begin
            q_next = rgt;
        end
        else if (ctl.squeeze)
        begin
            if (left_role)
            begin
                if (!q_reg.live && rgt.live)
                begin
                    q_next = rgt;
                end
            end
            else
            begin
                if (!lft.live && q_reg.live)
                begin
                    q_next = lft;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

@@ hw/rtl/dea_seq.sv @@
`timescale 1ns / 1ps
// Sequencer of the extent allocator: runs passes over the cell chain head.
// Depends on dea_pkg for payload structs, codes and the cell control struct.
module dea_seq #(
    parameter int MAX_EXTENTS = dea_pkg::MAX_EXTENTS_DEF,
    parameter int ID_BITS     = dea_pkg::ID_BITS_DEF,
    parameter int ENTRY_W     = 2 + ID_BITS + dea_pkg::LEN_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  dea_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output dea_pkg::rsp_t                rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dea_pkg::LEN_W-1:0]    cfg_data,
    input  logic [ENTRY_W-1:0]           head,
    output logic [ENTRY_W-1:0]           push,
    output dea_pkg::cell_ctl_t           cell_ctl
);

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int SW = dea_pkg::LEN_W + CW;
    localparam int LW = dea_pkg::LEN_W;
    localparam int RW = dea_pkg::RES_W;

    typedef struct packed {
        logic               live;
        logic               free;
        logic [ID_BITS-1:0] owner;
        logic [LW-1:0]      len;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FORMAT, S_SCAN, S_WRITE, S_DELETE, S_SHOW,
        S_GATHER, S_SQUEEZE, S_MERGE, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               merge_after_reg, merge_after_next;
    logic [CW-1:0]      t_reg, t_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      w_reg, w_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [LW-1:0]      size_reg, size_next;
    logic [SW-1:0]      acc_reg, acc_next;
    logic               big_reg, big_next;
    logic [LW-1:0]      rem_reg, rem_next;
    entry_t             carry_reg, carry_next;
    logic               carry_v_reg, carry_v_next;
    entry_t             hold_reg, hold_next;
    logic               hold_v_reg, hold_v_next;
    logic               found_reg, found_next;
    logic [RW-1:0]      k_reg, k_next;
    logic [LW-1:0]      pos_reg, pos_next;
    logic [LW-1:0]      pend_reg, pend_next;
    logic               pend_v_reg, pend_v_next;
    dea_pkg::rsp_t      res_reg, res_next;
    dea_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [LW-1:0]      disk_reg, disk_next;

    entry_t             e;
    entry_t             ev;
    entry_t             x;
    entry_t             hole;
    entry_t             push_e;
    logic               v;
    logic               last_t;
    logic               out_free;
    logic               xv;
    logic               app;
    logic               match;
    logic               mergeable;

    assign e         = head;
    assign push      = push_e;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign hole      = '0;
    assign v         = (t_reg < count_reg);
    assign last_t    = (t_reg == CW'(MAX_EXTENTS - 1));
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        ev      = e;
        ev.live = v;
        app     = (t_reg == n_reg) && (n_reg < CW'(MAX_EXTENTS));
        xv      = (t_reg < n_reg) || app;
        x       = e;
        x.live  = 1'b1;
        if (app)
        begin
            x.free  = 1'b1;
            x.owner = '0;
            x.len   = acc_reg[LW-1:0];
        end
        mergeable = hold_v_reg && (hold_reg.free == x.free) &&
                    (x.free || (hold_reg.owner == x.owner));
        match = v && !e.free && (e.owner == id_reg) && (k_reg < RW'(dea_pkg::MAX_RESULTS));
    end

    always_comb
    begin
        state_next       = state_reg;
        merge_after_next = merge_after_reg;
        t_next           = t_reg;
        count_next       = count_reg;
        n_next           = n_reg;
        w_next           = w_reg;
        id_next          = id_reg;
        size_next        = size_reg;
        acc_next         = acc_reg;
        big_next         = big_reg;
        rem_next         = rem_reg;
        carry_next       = carry_reg;
        carry_v_next     = carry_v_reg;
        hold_next        = hold_reg;
        hold_v_next      = hold_v_reg;
        found_next       = found_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        pend_next        = pend_reg;
        pend_v_next      = pend_v_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        disk_next        = disk_reg;
        push_e           = hole;
        cell_ctl         = '0;

        if (cfg_valid)
        begin
            disk_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    id_next      = ID_BITS'(req.file_id);
                    size_next    = req.file_size;
                    t_next       = '0;
                    acc_next     = '0;
                    big_next     = 1'b0;
                    found_next   = 1'b0;
                    k_next       = '0;
                    pos_next     = '0;
                    pend_v_next  = 1'b0;
                    carry_v_next = 1'b0;
                    hold_v_next  = 1'b0;
                    n_next       = '0;
                    w_next       = '0;
                    res_next     = '{status: dea_pkg::STATUS_OK, position: '0, last: 1'b1};
                    case (req.kind)
                        dea_pkg::KIND_FORMAT:  state_next = S_FORMAT;
                        dea_pkg::KIND_WRITE:
                        begin
                            state_next = (req.file_size == '0) ? S_DONE : S_SCAN;
                        end
                        dea_pkg::KIND_SHOW:    state_next = S_SHOW;
                        dea_pkg::KIND_DELETE:  state_next = S_DELETE;
                        dea_pkg::KIND_COMPACT: state_next = S_GATHER;
                        default:               state_next = S_DONE;
                    endcase
                end
            end

            S_FORMAT:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                if (t_reg == '0)
                begin
                    push_e = '{live: 1'b1, free: 1'b1, owner: '0, len: disk_reg};
                end
                if (last_t)
                begin
                    count_next = CW'(1);
                    state_next = S_DONE;
                end
            end

            S_SCAN:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                push_e         = ev;
                if (v && e.free)
                begin
                    acc_next = acc_reg + SW'(e.len);
                    if (e.len > size_reg)
                    begin
                        big_next = 1'b1;
                    end
                end
                if (last_t)
                begin
                    t_next   = '0;
                    rem_next = size_reg;
                    if (acc_next < SW'(size_reg))
                    begin
                        res_next.status = dea_pkg::STATUS_DISK_FULL;
                        state_next      = S_DONE;
                    end
                    else if (count_reg == CW'(MAX_EXTENTS))
                    begin
                        res_next.status = dea_pkg::STATUS_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end

            S_WRITE:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                if (carry_v_reg)
                begin
                    // Entries behind an insertion move down by one place.
                    push_e       = carry_reg;
                    carry_next   = ev;
                    carry_v_next = v;
                end
                else if (!v)
                begin
                    push_e = hole;
                end
                else if (e.free && (rem_reg != '0) && (!big_reg || (e.len > size_reg)))
                begin
                    if (!big_reg && (e.len <= rem_reg))
                    begin
                        push_e       = ev;
                        push_e.free  = 1'b0;
                        push_e.owner = id_reg;
                        rem_next     = rem_reg - e.len;
                    end
                    else
                    begin
                        push_e       = '{live: 1'b1, free: 1'b0, owner: id_reg, len: rem_reg};
                        carry_next   = ev;
                        carry_next.len = e.len - rem_reg;
                        carry_v_next = 1'b1;
                        rem_next     = '0;
                        count_next   = count_reg + 1'b1;
                    end
                end
                else
                begin
                    push_e = ev;
                end
                if (last_t)
                begin
                    state_next = S_DONE;
                end
            end

            S_DELETE:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                push_e         = ev;
                if (v && !e.free && (e.owner == id_reg))
                begin
                    push_e.free  = 1'b1;
                    push_e.owner = '0;
                    found_next   = 1'b1;
                end
                if (last_t)
                begin
                    if (!found_next)
                    begin
                        res_next.status = dea_pkg::STATUS_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
            end

            S_SHOW:
            begin
                // The last flag is only known once the next match is seen, so
                // one position is held back and the pass waits on the output.
                if (!(match && pend_v_reg && !out_free))
                begin
                    cell_ctl.shift = 1'b1;
                    t_next         = t_reg + 1'b1;
                    push_e         = ev;
                    pos_next       = pos_reg + (v ? e.len : LW'(0));
                    if (match)
                    begin
                        if (pend_v_reg)
                        begin
                            rsp_next       = '{status: dea_pkg::STATUS_OK,
                                               position: pend_reg, last: 1'b0};
                            rsp_valid_next = 1'b1;
                        end
                        pend_next   = pos_reg;
                        pend_v_next = 1'b1;
                        k_next      = k_reg + 1'b1;
                    end
                    if (last_t)
                    begin
                        if (pend_v_next)
                        begin
                            res_next.position = pend_next;
                        end
                        else
                        begin
                            res_next.status = dea_pkg::STATUS_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_GATHER:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                if (v && !e.free)
                begin
                    push_e = ev;
                    n_next = n_reg + 1'b1;
                end
                else if (v)
                begin
                    acc_next = acc_reg + SW'(e.len);
                end
                if (last_t)
                begin
                    t_next           = '0;
                    merge_after_next = 1'b1;
                    state_next       = S_SQUEEZE;
                end
            end

            S_SQUEEZE:
            begin
                cell_ctl.squeeze = 1'b1;
                cell_ctl.phase   = t_reg[0];
                t_next           = t_reg + 1'b1;
                if (last_t)
                begin
                    t_next     = '0;
                    state_next = merge_after_reg ? S_MERGE : S_DONE;
                end
            end

            S_MERGE:
            begin
                // The held entry leaves the sequencer one place late.
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + 1'b1;
                if (xv)
                begin
                    if (mergeable)
                    begin
                        hold_next.len = hold_reg.len + x.len;
                        push_e        = hole;
                    end
                    else
                    begin
                        push_e      = hold_v_reg ? hold_reg : hole;
                        hold_next   = x;
                        hold_v_next = 1'b1;
                        w_next      = w_reg + 1'b1;
                    end
                end
                else
                begin
                    push_e      = hold_v_reg ? hold_reg : hole;
                    hold_v_next = 1'b0;
                end
                if (t_reg == CW'(MAX_EXTENTS))
                begin
                    count_next       = w_next;
                    t_next           = '0;
                    merge_after_next = 1'b0;
                    state_next       = S_SQUEEZE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            merge_after_reg <= 1'b0;
            t_reg           <= '0;
            count_reg       <= '0;
            n_reg           <= '0;
            w_reg           <= '0;
            id_reg          <= '0;
            size_reg        <= '0;
            acc_reg         <= '0;
            big_reg         <= 1'b0;
            rem_reg         <= '0;
            carry_reg       <= '0;
            carry_v_reg     <= 1'b0;
            hold_reg        <= '0;
            hold_v_reg      <= 1'b0;
            found_reg       <= 1'b0;
            k_reg           <= '0;
            pos_reg         <= '0;
            pend_reg        <= '0;
            pend_v_reg      <= 1'b0;
            res_reg         <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            disk_reg        <= dea_pkg::DISK_BLOCKS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            merge_after_reg <= merge_after_next;
            t_reg           <= t_next;
            count_reg       <= count_next;
            n_reg           <= n_next;
            w_reg           <= w_next;
            id_reg          <= id_next;
            size_reg        <= size_next;
            acc_reg         <= acc_next;
            big_reg         <= big_next;
            rem_reg         <= rem_next;
            carry_reg       <= carry_next;
            carry_v_reg     <= carry_v_next;
            hold_reg        <= hold_next;
            hold_v_reg      <= hold_v_next;
            found_reg       <= found_next;
            k_reg           <= k_next;
            pos_reg         <= pos_next;
            pend_reg        <= pend_next;
            pend_v_reg      <= pend_v_next;
            res_reg         <= res_next;
            rsp_reg         <= rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
            disk_reg        <= disk_next;
        end
    end

endmodule

@@ bench/dea_checker.sv @@
`timescale 1ns / 1ps
// Checker for the disk extent allocator: predicts the responses of every request
// transaction and compares them with the responses that the block hands out.
// Depends on dea_pkg for the payload types, codes and table size.
module dea_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  dea_pkg::req_t             req,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  dea_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [dea_pkg::LEN_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending
);

    localparam int SLOTS = dea_pkg::MAX_EXTENTS_DEF;

    // Shadow copy of the extent table and the volume size.
    logic [dea_pkg::LEN_W-1:0] volume_blocks;
    logic [dea_pkg::FID_W-1:0] owner_tab [SLOTS];
    logic                      free_tab  [SLOTS];
    logic [dea_pkg::LEN_W-1:0] length_tab[SLOTS];
    int                        used;
    dea_pkg::rsp_t             rsp_queue[$];

    assign pending = rsp_queue.size();

    function automatic void open_slot(int at, logic [dea_pkg::FID_W-1:0] id,
                                      logic [dea_pkg::LEN_W-1:0] len);
        for (int i = used; i > at; i--) begin
            owner_tab[i]  = owner_tab[i-1];
            free_tab[i]   = free_tab[i-1];
            length_tab[i] = length_tab[i-1];
        end
        owner_tab[at]  = id;
        free_tab[at]   = 1'b0;
        length_tab[at] = len;
        used++;
    endfunction

    function automatic logic [dea_pkg::STAT_W-1:0] allocate(logic [dea_pkg::FID_W-1:0] id,
                                                            logic [dea_pkg::LEN_W-1:0] size);
        int unsigned               space;
        logic [dea_pkg::LEN_W-1:0] remain;
        space = 0;
        if (size == 0)
            return dea_pkg::STATUS_OK;
        for (int i = 0; i < used; i++)
            if (free_tab[i])
                space += length_tab[i];
        if (space < size)
            return dea_pkg::STATUS_DISK_FULL;
        if (used >= SLOTS)
            return dea_pkg::STATUS_TABLE_FULL;
        // A free extent strictly larger than the request takes the whole file.
        for (int i = 0; i < used; i++) begin
            if (free_tab[i] && length_tab[i] > size) begin
                open_slot(i, id, size);
                length_tab[i+1] -= size;
                return dea_pkg::STATUS_OK;
            end
        end
        // Otherwise free extents are consumed in order and the last one is split if it is longer.
        remain = size;
        for (int i = 0; i < used && remain > 0; i++) begin
            if (free_tab[i]) begin
                if (length_tab[i] <= remain) begin
                    free_tab[i]  = 1'b0;
                    owner_tab[i] = id;
                    remain -= length_tab[i];
                end else begin
                    open_slot(i, id, remain);
                    length_tab[i+1] -= remain;
                    remain = 0;
                end
            end
        end
        return dea_pkg::STATUS_OK;
    endfunction

    function automatic void squeeze_table();
        int          n;
        int          w;
        int unsigned gathered;
        n = 0;
        gathered = 0;
        for (int i = 0; i < used; i++) begin
            if (free_tab[i]) begin
                gathered += length_tab[i];
            end else begin
                owner_tab[n]  = owner_tab[i];
                free_tab[n]   = 1'b0;
                length_tab[n] = length_tab[i];
                n++;
            end
        end
        if (n < SLOTS) begin
            owner_tab[n]  = '0;
            free_tab[n]   = 1'b1;
            length_tab[n] = gathered[dea_pkg::LEN_W-1:0];
            n++;
        end
        w = 0;
        for (int i = 0; i < n; i++) begin
            if (w > 0 && free_tab[w-1] == free_tab[i] &&
                (free_tab[i] || owner_tab[w-1] == owner_tab[i])) begin
                length_tab[w-1] = length_tab[w-1] + length_tab[i];
            end else begin
                owner_tab[w]  = owner_tab[i];
                free_tab[w]   = free_tab[i];
                length_tab[w] = length_tab[i];
                w++;
            end
        end
        used = w;
    endfunction

    function automatic int owned_extents(logic [dea_pkg::FID_W-1:0] id);
        int hits;
        hits = 0;
        for (int i = 0; i < used; i++)
            if (!free_tab[i] && owner_tab[i] == id)
                hits++;
        return hits;
    endfunction

    function automatic void predict_request(dea_pkg::req_t r);
        dea_pkg::rsp_t             one;
        logic [dea_pkg::LEN_W-1:0] offset;
        int                        hits;
        int                        k;
        one = '{status: dea_pkg::STATUS_OK, position: '0, last: 1'b1};
        hits = owned_extents(r.file_id);
        case (r.kind)
            dea_pkg::KIND_FORMAT: begin
                used = 1;
                owner_tab[0]  = '0;
                free_tab[0]   = 1'b1;
                length_tab[0] = volume_blocks;
            end
            dea_pkg::KIND_WRITE: one.status = allocate(r.file_id, r.file_size);
            dea_pkg::KIND_SHOW: begin
                if (hits == 0) begin
                    one.status = dea_pkg::STATUS_NOT_FOUND;
                end else begin
                    if (hits > dea_pkg::MAX_RESULTS)
                        hits = dea_pkg::MAX_RESULTS;
                    offset = '0;
                    k = 0;
                    for (int i = 0; i < used && k < hits; i++) begin
                        if (!free_tab[i] && owner_tab[i] == r.file_id) begin
                            rsp_queue.push_back('{status: dea_pkg::STATUS_OK,
                                                  position: offset,
                                                  last: (k == hits - 1)});
                            k++;
                        end
                        offset = offset + length_tab[i];
                    end
                    return;
                end
            end
            dea_pkg::KIND_DELETE: begin
                if (hits == 0) begin
                    one.status = dea_pkg::STATUS_NOT_FOUND;
                end else begin
                    for (int i = 0; i < used; i++)
                        if (!free_tab[i] && owner_tab[i] == r.file_id) begin
                            free_tab[i]  = 1'b1;
                            owner_tab[i] = '0;
                        end
                end
            end
            dea_pkg::KIND_COMPACT: squeeze_table();
            default: ;
        endcase
        rsp_queue.push_back(one);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        dea_pkg::rsp_t want;
        if (!rst_n) begin
            volume_blocks <= dea_pkg::DISK_BLOCKS_RESET;
            used = 0;
            rsp_queue.delete();
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                volume_blocks <= cfg_data;
            // Responses of earlier requests are checked before a new request is predicted.
            if (rsp_valid && rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, rsp);
                    errors <= errors + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (rsp.status !== want.status || rsp.position !== want.position ||
                        rsp.last !== want.last) begin
                        $display("%0t: response mismatch, expected %p, got %p",
                                 $time, want, rsp);
                        errors <= errors + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                predict_request(req);
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the disk extent allocator bench: clock, reset, request and response traffic,
// configuration writes, a watchdog and the verdict. Depends on dea_pkg,
// disk_extent_allocator and dea_checker.
module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    dea_pkg::req_t             req;
    logic                      rsp_valid;
    logic                      rsp_ready;
    dea_pkg::rsp_t             rsp;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [dea_pkg::LEN_W-1:0] cfg_data;
    int                        errors;
    int                        pending;

    // When steady is set both sides run without gaps; hold_off asks the response
    // side for one long stall while requests keep coming.
    bit                        steady;
    bit                        hold_off;
    logic [dea_pkg::LEN_W-1:0] volume;

    disk_extent_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dea_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Response side: random stalls, plus the one long hold-off when asked for.
    initial begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) begin
                rsp_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
                rsp_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    rsp_ready <= 1'b1;
                end else begin
                    rsp_ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count. The
    // handshakes are looked at on the falling edge, where they have settled for
    // the rising edge that follows.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(negedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One request transaction. Valid is lowered only when a gap precedes the item,
    // so back-to-back items keep it high without a second assignment in the step.
    // Ready is looked at on the falling edge, so the task returns at the rising
    // edge that accepts the transaction.
    task automatic send(logic [dea_pkg::KIND_W-1:0] kind, logic [dea_pkg::FID_W-1:0] id,
                        logic [dea_pkg::LEN_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{kind: kind, file_id: id, file_size: size};
        @(negedge clk);
        while (!req_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // The register is written only once every response is back and the block has
    // had time to finish anything that produces no response.
    task automatic set_volume(logic [dea_pkg::LEN_W-1:0] blocks);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= blocks;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        volume = blocks;
    endtask

    // File identities come mostly from a small pool so that shows and deletes hit.
    function automatic logic [dea_pkg::FID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return dea_pkg::FID_W'($urandom_range(1, 6));
        return dea_pkg::FID_W'($urandom);
    endfunction

    function automatic logic [dea_pkg::LEN_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return dea_pkg::LEN_W'($urandom_range(1, volume / 10 + 1));
        if (roll < 90)
            return dea_pkg::LEN_W'($urandom_range(1, volume + 1));
        return dea_pkg::LEN_W'($urandom_range(1, (1 << dea_pkg::LEN_W) - 1));
    endfunction

    task automatic random_phase(int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0)
                steady = 1'b1;
            else if (n % 100 == 30)
                steady = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send(dea_pkg::KIND_FORMAT, dea_pkg::FID_W'($urandom),
                     dea_pkg::LEN_W'($urandom));
            else if (roll < 48)
                send(dea_pkg::KIND_WRITE, pick_id(), pick_size());
            else if (roll < 68)
                send(dea_pkg::KIND_SHOW, pick_id(), dea_pkg::LEN_W'($urandom));
            else if (roll < 84)
                send(dea_pkg::KIND_DELETE, pick_id(), dea_pkg::LEN_W'($urandom));
            else if (roll < 96)
                send(dea_pkg::KIND_COMPACT, dea_pkg::FID_W'($urandom),
                     dea_pkg::LEN_W'($urandom));
            else
                send(dea_pkg::KIND_W'($urandom_range(5, 7)), dea_pkg::FID_W'($urandom),
                     dea_pkg::LEN_W'($urandom));
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        hold_off  = 1'b0;
        volume    = dea_pkg::DISK_BLOCKS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An unformatted table: nothing to find, no room, compact of nothing.
        send(dea_pkg::KIND_WRITE, 16'h0001, 20'd5);
        send(dea_pkg::KIND_SHOW, 16'h0001, '0);
        send(dea_pkg::KIND_DELETE, 16'h0001, '0);
        send(dea_pkg::KIND_COMPACT, '0, '0);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        send(dea_pkg::KIND_WRITE, 16'hFFFF, 20'd0);
        send(dea_pkg::KIND_WRITE, 16'hFFFF, 20'd100);
        send(dea_pkg::KIND_WRITE, 16'h0000, 20'd924);
        send(dea_pkg::KIND_WRITE, 16'h0002, 20'd1);
        send(dea_pkg::KIND_DELETE, 16'hFFFF, '0);
        send(dea_pkg::KIND_WRITE, 16'h0002, 20'hFFFFF);
        send(dea_pkg::KIND_WRITE, 16'h0002, 20'd60);
        send(dea_pkg::KIND_WRITE, 16'h0002, 20'd40);
        send(dea_pkg::KIND_SHOW, 16'h0002, '0);
        send(dea_pkg::KIND_COMPACT, '0, '0);
        send(dea_pkg::KIND_SHOW, 16'h0000, '0);
        send(dea_pkg::KIND_W'(5), 16'h1234, 20'd3);
        send(dea_pkg::KIND_W'(6), '0, '0);
        send(dea_pkg::KIND_W'(7), 16'hFFFF, 20'hFFFFF);

        // Long response stall while requests keep arriving, so the block backs up.
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            send(dea_pkg::KIND_SHOW, 16'h0002, '0);

        set_volume('0);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        send(dea_pkg::KIND_COMPACT, '0, '0);
        set_volume(20'd1);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        send(dea_pkg::KIND_WRITE, 16'h0003, 20'd1);

        // Random traffic under several volume sizes, the extremes among them.
        set_volume(20'd64);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        random_phase(150);
        set_volume(20'hFFFFF);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        random_phase(120);
        set_volume(dea_pkg::LEN_W'($urandom_range(2, 4000)));
        send(dea_pkg::KIND_FORMAT, '0, '0);
        random_phase(120);
        set_volume(dea_pkg::DISK_BLOCKS_RESET);
        send(dea_pkg::KIND_FORMAT, '0, '0);
        random_phase(110);

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dea_pkg.sv
hw/rtl/dea_cell.sv
hw/rtl/dea_seq.sv
hw/rtl/disk_extent_allocator.sv
bench/dea_checker.sv
bench/testbench.sv
